### design/urh_pkg.sv
// ============================================================================
// urh_pkg - shared types and constants of the undo/redo history ring
// Request codes, sequencer states, field widths and the register map.
// ============================================================================
`default_nettype none

package urh_pkg;

	localparam int TAG_W   = 16;
	localparam int SIZE_W  = 16;
	localparam int CAP_W   = 24;
	localparam int TOTAL_W = 25;	// capacity plus one entry before eviction
	localparam int EDIT_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [PADDR_W-1:0] CAP_ADDR  = 3'd0;
	localparam logic [CAP_W-1:0]   CAP_RESET = 24'd65536;

	typedef enum logic [1:0] {
		REQ_COMMIT = 2'd0,
		REQ_UNDO   = 2'd1,
		REQ_REDO   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DROP_CHK,
		ST_DROP_SUB,
		ST_FULL_SUB,
		ST_APPEND,
		ST_EVICT_CHK,
		ST_EVICT_SUB,
		ST_REST_RD,
		ST_REST_OUT,
		ST_DONE
	} state_t;

	// control of the shared byte-total unit
	typedef struct packed {
		logic sel_rd;	// operand from store read data, else committed size
		logic sub;	// subtract, else add
	} alu_ctl_t;

endpackage

`default_nettype wire

### design/urh_store.sv
// ============================================================================
// urh_store - entry memory of the history ring
// One tag/size word per slot; one address, write or registered read.
// ============================================================================
`default_nettype none

module urh_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata_q
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

endmodule

`default_nettype wire

### design/urh_alu.sv
// ============================================================================
// urh_alu - shared byte-total unit
// Adds or subtracts one entry size and compares the total with capacity.
// ============================================================================
`default_nettype none

module urh_alu (
	input  wire urh_pkg::alu_ctl_t               ctl,
	input  wire logic [urh_pkg::TOTAL_W-1:0]     total,
	input  wire logic [urh_pkg::SIZE_W-1:0]      rd_size,
	input  wire logic [urh_pkg::SIZE_W-1:0]      new_size,
	input  wire logic [urh_pkg::CAP_W-1:0]       cap,
	output logic      [urh_pkg::TOTAL_W-1:0]     result,
	output logic                                 over
);

	logic [urh_pkg::TOTAL_W-1:0] operand;

	always_comb begin
		operand = ctl.sel_rd ? urh_pkg::TOTAL_W'(rd_size) : urh_pkg::TOTAL_W'(new_size);
		result  = ctl.sub ? (total - operand) : (total + operand);
		over    = total > urh_pkg::TOTAL_W'(cap);
	end

endmodule

`default_nettype wire

### design/undo_redo_history_ring.sv
// ============================================================================
// undo_redo_history_ring - byte-budgeted undo/redo history
// Sequencer, state registers and APB register port around the entry store.
// ============================================================================
// An item is taken when start is high and busy is low; busy then stays high
// until its result has been shown. Every item gives exactly one result, held
// on the result ports for the single cycle in which done is high; there is no
// way to hold it off, so sample it then. A commit drops every redoable entry,
// evicts the oldest entry when the ring is full, appends the new entry and
// evicts oldest entries while over budget. In the drop and evict loops each
// step reads one size from the single-port entry store (registered read) and
// then runs it through the one shared add/subtract unit; the full-ring
// eviction reads its size during the drop check, so it needs no read step of
// its own. The store itself has no reset; only data of held entries is ever
// used. capacity_bytes lives at byte address 0 and should be written only
// while busy is low.
// ============================================================================
`default_nettype none

module undo_redo_history_ring #(
	parameter int HISTORY_DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// command channel
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [1:0]                            req_type,
	input  wire logic [urh_pkg::TAG_W-1:0]             entry_tag,
	input  wire logic [urh_pkg::SIZE_W-1:0]            entry_size,
	// result channel
	output logic                                       done,
	output logic                                       restore_valid,
	output logic                                       restore_is_redo,
	output logic [urh_pkg::TAG_W-1:0]                  restore_tag,
	output logic [urh_pkg::SIZE_W-1:0]                 restore_size,
	output logic [urh_pkg::CAP_W-1:0]                  bytes_held,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0]         entries_held,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0]         undo_depth,
	output logic [urh_pkg::EDIT_W-1:0]                 edit_count,
	// register port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [urh_pkg::PADDR_W-1:0]           paddr,
	input  wire logic [31:0]                           pwdata,
	output logic [31:0]                                prdata,
	output logic                                       pready
);

	localparam int IW = $clog2(HISTORY_DEPTH);	// slot index
	localparam int CW = $clog2(HISTORY_DEPTH + 1);	// entry count
	localparam int SW = IW + 1;			// slot sum before wrap
	localparam int DW = urh_pkg::TAG_W + urh_pkg::SIZE_W;

	urh_pkg::state_t state_q, state_nxt;

	logic [urh_pkg::CAP_W-1:0]   cap_q;
	logic [IW-1:0]               oldest_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               undone_q;
	logic [urh_pkg::TOTAL_W-1:0] total_q;
	logic [urh_pkg::EDIT_W-1:0]  edit_q;

	// latched item and restore result
	urh_pkg::req_t               req_q;
	logic [urh_pkg::TAG_W-1:0]   tag_q;
	logic [urh_pkg::SIZE_W-1:0]  size_q;
	logic                        rest_valid_q;
	logic                        rest_redo_q;
	logic [urh_pkg::TAG_W-1:0]   rest_tag_q;
	logic [urh_pkg::SIZE_W-1:0]  rest_size_q;

	logic                        accept;
	urh_pkg::req_t               req_in;
	logic                        cfg_wr;

	logic [CW-1:0]               pos_c;
	logic [SW-1:0]               sum_c;
	logic [SW-1:0]               slot_c;
	logic [IW-1:0]               addr_c;
	logic                        mem_we;
	logic [DW-1:0]               rd_data;
	urh_pkg::alu_ctl_t           alu_ctl;
	logic [urh_pkg::TOTAL_W-1:0] alu_res;
	logic                        alu_over;
	logic [IW-1:0]               oldest_inc;

	assign accept = start && !busy;
	assign req_in = urh_pkg::req_t'(req_type);
	assign cfg_wr = psel && penable && pwrite && pready;

	// ---------------------------------------------------------------- store
	urh_store #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (IW),
		.DW    (DW)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.addr    (addr_c),
		.wdata   ({tag_q, size_q}),
		.rdata_q (rd_data)
	);

	// --------------------------------------------------- shared byte unit
	urh_alu u_alu (
		.ctl      (alu_ctl),
		.total    (total_q),
		.rd_size  (rd_data[urh_pkg::SIZE_W-1:0]),
		.new_size (size_q),
		.cap      (cap_q),
		.result   (alu_res),
		.over     (alu_over)
	);

	// logical position -> physical slot, oldest entry is position 0
	always_comb begin
		sum_c  = SW'(oldest_q) + SW'(pos_c);
		slot_c = (sum_c >= SW'(HISTORY_DEPTH)) ? (sum_c - SW'(HISTORY_DEPTH)) : sum_c;
		addr_c = slot_c[IW-1:0];
		oldest_inc = (oldest_q == IW'(HISTORY_DEPTH - 1)) ? '0 : (oldest_q + 1'b1);
	end

	// ----------------------------------------------------------- next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			urh_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req_in)
						urh_pkg::REQ_COMMIT:
							state_nxt = (entry_size != '0) ? urh_pkg::ST_DROP_CHK
							                              : urh_pkg::ST_DONE;
						urh_pkg::REQ_UNDO:
							state_nxt = (undone_q < count_q) ? urh_pkg::ST_REST_RD
							                                 : urh_pkg::ST_DONE;
						urh_pkg::REQ_REDO:
							state_nxt = (undone_q != '0) ? urh_pkg::ST_REST_RD
							                             : urh_pkg::ST_DONE;
						urh_pkg::REQ_CLEAR:
							state_nxt = urh_pkg::ST_DONE;
						default:
							state_nxt = urh_pkg::ST_DONE;
					endcase
				end
			end
			urh_pkg::ST_DROP_CHK: begin
				if (undone_q != '0) begin
					state_nxt = urh_pkg::ST_DROP_SUB;
				end else if (count_q == CW'(HISTORY_DEPTH)) begin
					state_nxt = urh_pkg::ST_FULL_SUB;
				end else begin
					state_nxt = urh_pkg::ST_APPEND;
				end
			end
			urh_pkg::ST_DROP_SUB:  state_nxt = urh_pkg::ST_DROP_CHK;
			urh_pkg::ST_FULL_SUB:  state_nxt = urh_pkg::ST_APPEND;
			urh_pkg::ST_APPEND:    state_nxt = urh_pkg::ST_EVICT_CHK;
			urh_pkg::ST_EVICT_CHK: begin
				if (alu_over && (count_q != '0)) begin
					state_nxt = urh_pkg::ST_EVICT_SUB;
				end else begin
					state_nxt = urh_pkg::ST_DONE;
				end
			end
			urh_pkg::ST_EVICT_SUB: state_nxt = urh_pkg::ST_EVICT_CHK;
			urh_pkg::ST_REST_RD:   state_nxt = urh_pkg::ST_REST_OUT;
			urh_pkg::ST_REST_OUT:  state_nxt = urh_pkg::ST_DONE;
			urh_pkg::ST_DONE:      state_nxt = urh_pkg::ST_IDLE;
			default:               state_nxt = urh_pkg::ST_IDLE;
		endcase
	end

	// -------------------------------------------------------------- outputs
	always_comb begin
		busy           = (state_q != urh_pkg::ST_IDLE);
		done           = (state_q == urh_pkg::ST_DONE);
		mem_we         = 1'b0;
		pos_c          = '0;	// oldest entry unless noted
		alu_ctl.sel_rd = 1'b1;
		alu_ctl.sub    = 1'b1;
		unique case (state_q)
			urh_pkg::ST_DROP_CHK: begin
				// newest entry when dropping, else oldest for a full ring
				if (undone_q != '0) begin
					pos_c = count_q - 1'b1;
				end
			end
			urh_pkg::ST_APPEND: begin
				pos_c          = count_q;
				mem_we         = 1'b1;
				alu_ctl.sel_rd = 1'b0;
				alu_ctl.sub    = 1'b0;
			end
			urh_pkg::ST_REST_RD: begin
				// undo already advanced undone; redo reads before stepping
				pos_c = count_q - undone_q;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------ control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= urh_pkg::ST_IDLE;
			cap_q    <= urh_pkg::CAP_RESET;
			oldest_q <= '0;
			count_q  <= '0;
			undone_q <= '0;
			total_q  <= '0;
			edit_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr && (paddr == urh_pkg::CAP_ADDR)) begin
				cap_q <= pwdata[urh_pkg::CAP_W-1:0];
			end
			unique case (state_q)
				urh_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (req_in)
							urh_pkg::REQ_COMMIT: begin
								// every redoable entry goes, each one an edit undone
								if (entry_size != '0) begin
									edit_q <= edit_q - urh_pkg::EDIT_W'(undone_q) + 1'b1;
								end
							end
							urh_pkg::REQ_UNDO: begin
								if (undone_q < count_q) begin
									undone_q <= undone_q + 1'b1;
								end
							end
							urh_pkg::REQ_REDO: begin
							end
							urh_pkg::REQ_CLEAR: begin
								oldest_q <= '0;
								count_q  <= '0;
								undone_q <= '0;
								total_q  <= '0;
								edit_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				urh_pkg::ST_DROP_SUB: begin
					total_q  <= alu_res;
					count_q  <= count_q - 1'b1;
					undone_q <= undone_q - 1'b1;
				end
				urh_pkg::ST_FULL_SUB, urh_pkg::ST_EVICT_SUB: begin
					total_q  <= alu_res;
					count_q  <= count_q - 1'b1;
					oldest_q <= oldest_inc;
				end
				urh_pkg::ST_APPEND: begin
					total_q <= alu_res;
					count_q <= count_q + 1'b1;
				end
				urh_pkg::ST_REST_OUT: begin
					if (req_q == urh_pkg::REQ_REDO) begin
						undone_q <= undone_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------ item and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req_in;
			tag_q        <= entry_tag;
			size_q       <= entry_size;
			rest_valid_q <= 1'b0;
			rest_redo_q  <= 1'b0;
			rest_tag_q   <= '0;
			rest_size_q  <= '0;
		end else if (state_q == urh_pkg::ST_REST_OUT) begin
			rest_valid_q <= 1'b1;
			rest_redo_q  <= (req_q == urh_pkg::REQ_REDO);
			rest_tag_q   <= rd_data[DW-1:urh_pkg::SIZE_W];
			rest_size_q  <= rd_data[urh_pkg::SIZE_W-1:0];
		end
	end

	assign restore_valid   = rest_valid_q;
	assign restore_is_redo = rest_redo_q;
	assign restore_tag     = rest_tag_q;
	assign restore_size    = rest_size_q;
	assign bytes_held      = total_q[urh_pkg::CAP_W-1:0];
	assign entries_held    = count_q;
	assign undo_depth      = undone_q;
	assign edit_count      = edit_q;

	// register port: always ready, one register
	assign pready = 1'b1;
	assign prdata = (paddr == urh_pkg::CAP_ADDR) ? 32'(cap_q) : '0;

`ifndef SYNTHESIS
	a_undone_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		undone_q <= count_q)
		else $error("undone entries exceed held entries");

	a_count_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HISTORY_DEPTH))
		else $error("entry count exceeds ring depth");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item accepted without going busy");

	// an empty commit evicts nothing, so a lowered budget may still be exceeded
	a_commit_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (req_q == urh_pkg::REQ_COMMIT) && (size_q != '0))
		|-> (total_q <= urh_pkg::TOTAL_W'(cap_q)))
		else $error("commit finished over byte budget");

	a_redo_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == urh_pkg::ST_REST_OUT && req_q == urh_pkg::REQ_REDO)
		|=> (undone_q == $past(undone_q) - 1'b1))
		else $error("redo did not step position forward");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for undo_redo_history_ring
// Drives commit/undo/redo/clear items through the start/busy handshake,
// predicts every result with a cycle-free model of the history, and compares
// each done strobe field by field. The byte budget is reprogrammed between
// phases over the register port and read back each time.
// ============================================================================

module tb;

	localparam int DEPTH        = 64;
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int SHOWN_MAX    = 10;

	// one result of the block, as predicted
	typedef struct packed {
		logic                       restore_valid;
		logic                       restore_is_redo;
		logic [urh_pkg::TAG_W-1:0]  restore_tag;
		logic [urh_pkg::SIZE_W-1:0] restore_size;
		logic [urh_pkg::CAP_W-1:0]  bytes_held;
		logic [CNT_W-1:0]           entries_held;
		logic [CNT_W-1:0]           undo_depth;
		logic [urh_pkg::EDIT_W-1:0] edit_count;
	} step_report_t;

	// ------------------------------------------------------------------------
	// clock, reset, stimulus signals (all known from time zero)
	// ------------------------------------------------------------------------
	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        start      = 1'b0;
	urh_pkg::req_t               req_type   = urh_pkg::REQ_COMMIT;
	logic [urh_pkg::TAG_W-1:0]   entry_tag  = '0;
	logic [urh_pkg::SIZE_W-1:0]  entry_size = '0;
	logic                        psel       = 1'b0;
	logic                        penable    = 1'b0;
	logic                        pwrite     = 1'b0;
	logic [urh_pkg::PADDR_W-1:0] paddr      = urh_pkg::CAP_ADDR;
	logic [31:0]                 pwdata     = '0;

	logic                        busy, done, restore_valid, restore_is_redo, pready;
	logic [urh_pkg::TAG_W-1:0]   restore_tag;
	logic [urh_pkg::SIZE_W-1:0]  restore_size;
	logic [urh_pkg::CAP_W-1:0]   bytes_held;
	logic [CNT_W-1:0]            entries_held, undo_depth;
	logic [urh_pkg::EDIT_W-1:0]  edit_count;
	logic [31:0]                 prdata;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	undo_redo_history_ring #(.HISTORY_DEPTH(DEPTH)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.entry_tag      (entry_tag),
		.entry_size     (entry_size),
		.done           (done),
		.restore_valid  (restore_valid),
		.restore_is_redo(restore_is_redo),
		.restore_tag    (restore_tag),
		.restore_size   (restore_size),
		.bytes_held     (bytes_held),
		.entries_held   (entries_held),
		.undo_depth     (undo_depth),
		.edit_count     (edit_count),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// ------------------------------------------------------------------------
	// history model: ring of entries, oldest first, newest at count-1
	// ------------------------------------------------------------------------
	logic [urh_pkg::TAG_W-1:0]   hist_tag  [DEPTH];
	logic [urh_pkg::SIZE_W-1:0]  hist_size [DEPTH];
	int unsigned                 hist_oldest   = 0;
	int unsigned                 hist_count    = 0;
	int unsigned                 hist_undone   = 0;
	logic [urh_pkg::TOTAL_W-1:0] hist_bytes    = '0;
	logic [urh_pkg::EDIT_W-1:0]  hist_edits    = '0;
	logic [urh_pkg::CAP_W-1:0]   hist_capacity = urh_pkg::CAP_RESET;

	step_report_t awaited_reports [$];
	int           mismatches  = 0;
	int           cycle_count = 0;
	bit           no_idle     = 1'b0;

	function automatic int unsigned slot_of_pos(int unsigned pos);
		return (hist_oldest + pos) % DEPTH;
	endfunction

	function automatic void drop_oldest();
		hist_bytes  -= urh_pkg::TOTAL_W'(hist_size[hist_oldest]);
		hist_oldest  = (hist_oldest + 1) % DEPTH;
		hist_count--;
	endfunction

	function automatic step_report_t advance_history(urh_pkg::req_t req,
			logic [urh_pkg::TAG_W-1:0] tag, logic [urh_pkg::SIZE_W-1:0] size);
		step_report_t r;
		int unsigned  s;
		r = '0;
		case (req)
		urh_pkg::REQ_COMMIT: begin
			if (size != 0) begin
				// redoable entries go first, and their edits are taken back
				while (hist_undone != 0 && hist_count != 0) begin
					s = slot_of_pos(hist_count - 1);
					hist_bytes -= urh_pkg::TOTAL_W'(hist_size[s]);
					hist_count--;
					hist_undone--;
					hist_edits--;
				end
				hist_undone = 0;
				if (hist_count >= DEPTH)
					drop_oldest();
				s = slot_of_pos(hist_count);
				hist_tag[s]  = tag;
				hist_size[s] = size;
				hist_count++;
				hist_bytes += urh_pkg::TOTAL_W'(size);
				// an entry over budget takes everything older with it
				while (hist_bytes > urh_pkg::TOTAL_W'(hist_capacity) && hist_count != 0)
					drop_oldest();
				hist_edits++;
			end
		end
		urh_pkg::REQ_UNDO: begin
			if (hist_undone < hist_count) begin
				hist_undone++;
				s = slot_of_pos(hist_count - hist_undone);
				r.restore_valid = 1'b1;
				r.restore_tag   = hist_tag[s];
				r.restore_size  = hist_size[s];
			end
		end
		urh_pkg::REQ_REDO: begin
			if (hist_undone != 0 && hist_undone <= hist_count) begin
				s = slot_of_pos(hist_count - hist_undone);
				r.restore_valid   = 1'b1;
				r.restore_is_redo = 1'b1;
				r.restore_tag     = hist_tag[s];
				r.restore_size    = hist_size[s];
				hist_undone--;
			end
		end
		default: begin
			// clear keeps the budget
			hist_oldest = 0;
			hist_count  = 0;
			hist_undone = 0;
			hist_bytes  = '0;
			hist_edits  = '0;
		end
		endcase
		r.bytes_held   = hist_bytes[urh_pkg::CAP_W-1:0];
		r.entries_held = hist_count[CNT_W-1:0];
		r.undo_depth   = hist_undone[CNT_W-1:0];
		r.edit_count   = hist_edits;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// result checking: done is a one-cycle strobe, sampled at the edge ending it
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= SHOWN_MAX)
				$display("%0t %s: expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		step_report_t want;
		if (arst_n && done) begin
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("%0t result strobe with no item outstanding", $time);
			end else begin
				want = awaited_reports.pop_front();
				check_field("restore_valid", 32'(want.restore_valid), 32'(restore_valid));
				check_field("restore_is_redo", 32'(want.restore_is_redo),
					32'(restore_is_redo));
				check_field("restore_tag", 32'(want.restore_tag), 32'(restore_tag));
				check_field("restore_size", 32'(want.restore_size), 32'(restore_size));
				check_field("bytes_held", 32'(want.bytes_held), 32'(bytes_held));
				check_field("entries_held", 32'(want.entries_held), 32'(entries_held));
				check_field("undo_depth", 32'(want.undo_depth), 32'(undo_depth));
				check_field("edit_count", want.edit_count, edit_count);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// drivers; every task starts and ends on a rising edge
	// ------------------------------------------------------------------------
	// start stays high on return so back-to-back items need no extra NBA
	task automatic send_item(input urh_pkg::req_t req, input logic [urh_pkg::TAG_W-1:0] tag,
			input logic [urh_pkg::SIZE_W-1:0] size);
		start      <= 1'b1;
		req_type   <= req;
		entry_tag  <= tag;
		entry_size <= size;
		do @(posedge clk); while (busy);
		awaited_reports.push_back(advance_history(req, tag, size));
	endtask

	task automatic maybe_idle();
		if (!no_idle && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// hold off until every predicted result has shown up and the block is free
	task automatic drain_results();
		start <= 1'b0;
		while (awaited_reports.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic reg_access(input logic write, input logic [urh_pkg::PADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_capacity();
		logic [31:0] rd;
		reg_access(1'b0, urh_pkg::CAP_ADDR, 32'd0, rd);
		check_field("capacity_bytes", 32'(hist_capacity), 32'(rd[urh_pkg::CAP_W-1:0]));
	endtask

	task automatic set_capacity(input logic [urh_pkg::CAP_W-1:0] cap);
		logic [31:0] rd;
		drain_results();
		reg_access(1'b1, urh_pkg::CAP_ADDR, {8'd0, cap}, rd);
		hist_capacity = cap;
		check_capacity();
	endtask

	function automatic logic [urh_pkg::SIZE_W-1:0] pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return urh_pkg::SIZE_W'($urandom_range(1, 255));
		else if (p < 85)
			return urh_pkg::SIZE_W'($urandom_range(1, 65535));
		else if (p < 95)
			return (p & 1) ? 16'hFFFF : 16'd1;
		else
			return '0;	// ignored commit
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_capacity_reset();
		check_capacity();
	endtask

	// every request type, ignored cases, field extremes, drop of redo entries
	task automatic test_basic_ops();
		send_item(urh_pkg::REQ_UNDO, 16'hFFFF, 16'hFFFF); maybe_idle();	// nothing to undo
		send_item(urh_pkg::REQ_REDO, 16'h0000, 16'h0000); maybe_idle();	// nothing to redo
		send_item(urh_pkg::REQ_COMMIT, 16'h1234, 16'd0); maybe_idle();	// empty commit
		send_item(urh_pkg::REQ_COMMIT, 16'h0000, 16'd1); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'hFFFF, 16'hFFFF); maybe_idle();
		send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();	// all undone
		send_item(urh_pkg::REQ_REDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_REDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_REDO, 16'h0, 16'h0); maybe_idle();	// nothing undone
		send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'h5A5A, 16'd100); maybe_idle();	// drops one redo entry
		send_item(urh_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF); maybe_idle();
		send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'hA5A5, 16'h8000); maybe_idle();
	endtask

	// eviction over budget, oversized entry, exact fit, zero budget
	task automatic test_byte_budget();
		set_capacity(24'd100);
		send_item(urh_pkg::REQ_COMMIT, 16'h0101, 16'd60); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'h0202, 16'd50); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'h0303, 16'd200); maybe_idle();	// empties history
		send_item(urh_pkg::REQ_COMMIT, 16'h0404, 16'd100); maybe_idle();	// exactly at budget
		send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'h0505, 16'd1); maybe_idle();
		send_item(urh_pkg::REQ_COMMIT, 16'h0606, 16'd100); maybe_idle();
		set_capacity(24'd0);
		send_item(urh_pkg::REQ_COMMIT, 16'h0707, 16'd1); maybe_idle();
		send_item(urh_pkg::REQ_REDO, 16'h0, 16'h0); maybe_idle();
	endtask

	// fill past the ring depth, walk all the way back and forward again
	task automatic test_ring_full();
		set_capacity(24'hFFFFFF);
		send_item(urh_pkg::REQ_CLEAR, 16'h0, 16'h0); maybe_idle();
		repeat (DEPTH + 6) begin
			send_item(urh_pkg::REQ_COMMIT, urh_pkg::TAG_W'($urandom_range(0, 65535)),
				urh_pkg::SIZE_W'($urandom_range(1, 255)));
			maybe_idle();
		end
		repeat (DEPTH + 1) begin
			send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		end
		repeat (DEPTH + 1) begin
			send_item(urh_pkg::REQ_REDO, 16'h0, 16'h0); maybe_idle();
		end
		repeat (10) begin
			send_item(urh_pkg::REQ_UNDO, 16'h0, 16'h0); maybe_idle();
		end
		send_item(urh_pkg::REQ_COMMIT, 16'hBEEF, 16'd7); maybe_idle();	// drops ten
	endtask

	// commits mixed with undo/redo bursts; a little clear and random noise
	task automatic run_random_phase(input logic [urh_pkg::CAP_W-1:0] cap, input int items,
			input bit steady, input bit pause_midway);
		int            sent;
		int            pick;
		int            burst;
		bit            paused;
		urh_pkg::req_t req;
		set_capacity(cap);
		no_idle = steady;
		sent    = 0;
		paused  = 1'b0;
		while (sent < items) begin
			if (pause_midway && !paused && sent >= items / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_item(urh_pkg::REQ_COMMIT, urh_pkg::TAG_W'($urandom_range(0, 65535)),
					pick_size());
				sent++;
				maybe_idle();
			end else if (pick < 88) begin
				req   = (pick < 70) ? urh_pkg::REQ_UNDO : urh_pkg::REQ_REDO;
				burst = $urandom_range(1, 8);
				repeat (burst) begin
					send_item(req, urh_pkg::TAG_W'($urandom_range(0, 65535)),
						urh_pkg::SIZE_W'($urandom_range(0, 65535)));
					sent++;
					maybe_idle();
				end
			end else if (pick < 91) begin
				send_item(urh_pkg::REQ_CLEAR, urh_pkg::TAG_W'($urandom_range(0, 65535)),
					urh_pkg::SIZE_W'($urandom_range(0, 65535)));
				sent++;
				maybe_idle();
			end else begin
				send_item(urh_pkg::req_t'($urandom_range(0, 3)),
					urh_pkg::TAG_W'($urandom_range(0, 65535)),
					urh_pkg::SIZE_W'($urandom_range(0, 65535)));
				sent++;
				maybe_idle();
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_phases();
		run_random_phase(24'hFFFFFF, 140, 1'b1, 1'b0);	// no idling at all
		run_random_phase(24'd0, 80, 1'b0, 1'b0);
		run_random_phase(24'd300, 140, 1'b0, 1'b1);
		run_random_phase(urh_pkg::CAP_W'($urandom_range(1, 24'hFFFFFF)), 140, 1'b0, 1'b0);
		run_random_phase(urh_pkg::CAP_RESET, 140, 1'b0, 1'b0);
		run_random_phase(urh_pkg::CAP_W'($urandom_range(64, 4096)), 140, 1'b0, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_capacity_reset();
		test_basic_ops();
		test_byte_budget();
		test_ring_full();
		test_random_phases();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
design/urh_pkg.sv
design/urh_store.sv
design/urh_alu.sv
design/undo_redo_history_ring.sv
tb/sv/tb.sv
